// ===== rtl/core/mpq_pkg.sv =====
// mpq_pkg: shared types and constants of the minimum-first priority queue
// used by mpq_cell, min_priority_queue and mpq_checker
package mpq_pkg;

  localparam int unsigned DefaultCapacity = 16;
  localparam int unsigned ValueWidth      = 32;
  localparam int unsigned CountOutWidth   = 5;

  typedef enum logic {
    FUNC_ENQUEUE = 1'b0,
    FUNC_DEQUEUE = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  // operation broadcast to every cell of the chain
  typedef struct packed {
    logic insert;
    logic remove;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/mpq_cell.sv =====
// mpq_cell: one slot of the sorted cell chain
// depends on mpq_pkg for the control struct and value width
module mpq_cell
  import mpq_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cell_ctrl_t                   ctrl_i,
  input  logic signed [ValueWidth-1:0] new_value_i,
  input  logic                         prev_keep_i,
  input  logic signed [ValueWidth-1:0] prev_value_i,
  input  logic                         prev_valid_i,
  input  logic signed [ValueWidth-1:0] next_value_i,
  input  logic                         next_valid_i,
  output logic signed [ValueWidth-1:0] value_o,
  output logic                         valid_o,
  output logic                         keep_o
);

  logic signed [ValueWidth-1:0] value_d, value_q;
  logic                         valid_d, valid_q;

  // equal values stay ahead of a newcomer
  assign keep_o  = valid_q && (value_q <= new_value_i);
  assign value_o = value_q;
  assign valid_o = valid_q;

  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    if (ctrl_i.insert) begin
      if (!keep_o) begin
        if (prev_keep_i) begin
          value_d = new_value_i;
          valid_d = 1'b1;
        end else begin
          value_d = prev_value_i;
          valid_d = prev_valid_i;
        end
      end
    end else if (ctrl_i.remove) begin
      value_d = next_value_i;
      valid_d = next_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

endmodule

// ===== rtl/core/min_priority_queue.sv =====
// min_priority_queue: bounded minimum-first queue built as a sorted chain of cells
// depends on mpq_pkg and mpq_cell
//
// usage
//   slave channel: s_tuser_i selects the operation (0 enqueue, 1 dequeue),
//   s_tdata_i carries the signed value to enqueue (ignored on dequeue)
//   master channel: one result transaction per input transaction, with the
//   removed value, is_empty and entry_count in m_tdata_o and status in m_tuser_o
//   (0 done, 1 dequeue on empty queue, 2 enqueue on full queue)
// timing
//   every cell compares its value with the broadcast operand and moves data
//   one place along the chain in the same cycle, so an enqueue or a dequeue
//   retires each clock while the output does not stall; the result shows in
//   the output register the cycle after the input transaction
// stall
//   s_tready_o is high while the output register is empty or being taken; a
//   stalled receiver holds the result and blocks new input transactions
// reset
//   asynchronous, active low: all cells invalid, count zero, no result pending
module min_priority_queue
  import mpq_pkg::*;
#(
  parameter int unsigned CAPACITY = DefaultCapacity
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [31:0] s_tdata_i,   // [31:0] value
  input  logic        s_tuser_i,   // [0] func
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [39:0] m_tdata_o,   // [31:0] result_value, [32] is_empty,
                                   // [37:33] entry_count, [39:38] zero
  output logic [1:0]  m_tuser_o    // [1:0] status
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic signed [ValueWidth-1:0] cell_value [CAPACITY];
  logic                         cell_valid [CAPACITY];
  logic                         cell_keep  [CAPACITY];

  logic [CntW-1:0] count_d, count_q;
  logic            out_valid_d, out_valid_q;
  logic signed [ValueWidth-1:0] res_value_d, res_value_q;
  status_e         status_d, status_q;
  logic            empty_d, empty_q;
  logic [CountOutWidth-1:0] cnt_out_d, cnt_out_q;

  logic       accept;
  logic       full, empty;
  cell_ctrl_t ctrl;
  logic signed [ValueWidth-1:0] new_value;

  assign s_tready_o = !out_valid_q || m_tready_i;
  assign accept     = s_tvalid_i && s_tready_o;
  assign full       = (count_q == CntW'(CAPACITY));
  assign empty      = (count_q == '0);
  assign new_value  = s_tdata_i;

  // only legal operations reach the chain
  assign ctrl.insert = accept && (s_tuser_i == FUNC_ENQUEUE) && !full;
  assign ctrl.remove = accept && (s_tuser_i == FUNC_DEQUEUE) && !empty;

  // the chain: cell 0 holds the minimum, ties stay in arrival order
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                         prev_keep;
    logic signed [ValueWidth-1:0] prev_value;
    logic                         prev_valid;
    logic signed [ValueWidth-1:0] next_value;
    logic                         next_valid;

    if (i == 0) begin : g_head
      assign prev_keep  = 1'b1;
      assign prev_value = new_value;
      assign prev_valid = 1'b0;
    end else begin : g_body
      assign prev_keep  = cell_keep[i-1];
      assign prev_value = cell_value[i-1];
      assign prev_valid = cell_valid[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_value = '0;
      assign next_valid = 1'b0;
    end else begin : g_link
      assign next_value = cell_value[i+1];
      assign next_valid = cell_valid[i+1];
    end

    mpq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_value_i  (new_value),
      .prev_keep_i  (prev_keep),
      .prev_value_i (prev_value),
      .prev_valid_i (prev_valid),
      .next_value_i (next_value),
      .next_valid_i (next_valid),
      .value_o      (cell_value[i]),
      .valid_o      (cell_valid[i]),
      .keep_o       (cell_keep[i])
    );
  end

  // count update and result formation
  always_comb begin
    count_d     = count_q;
    out_valid_d = out_valid_q;
    res_value_d = res_value_q;
    status_d    = status_q;
    empty_d     = empty_q;
    cnt_out_d   = cnt_out_q;
    if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (accept) begin
      res_value_d = '0;
      status_d    = STATUS_DONE;
      if (ctrl.insert) begin
        count_d = count_q + 1'b1;
      end else if (ctrl.remove) begin
        count_d     = count_q - 1'b1;
        res_value_d = cell_value[0];
      end else if (s_tuser_i == FUNC_ENQUEUE) begin
        status_d = STATUS_FULL;
      end else begin
        status_d = STATUS_EMPTY;
      end
      out_valid_d = 1'b1;
      empty_d     = (count_d == '0);
      cnt_out_d   = CountOutWidth'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload needs no reset
  always_ff @(posedge clk_i) begin
    res_value_q <= res_value_d;
    status_q    <= status_d;
    empty_q     <= empty_d;
    cnt_out_q   <= cnt_out_d;
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {2'b00, cnt_out_q, empty_q, res_value_q};
  assign m_tuser_o  = status_q;

endmodule

// ===== rtl/core/mpq_checker.sv =====
// mpq_checker: port-level assertions for min_priority_queue
// depends on mpq_pkg; bound to the top level below
module mpq_checker
  import mpq_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_tvalid_i,
  input logic        s_tready_o,
  input logic        m_tvalid_o,
  input logic        m_tready_i,
  input logic [39:0] m_tdata_o,
  input logic [1:0]  m_tuser_o
);

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o)
    else $error("result dropped while stalled");

  // an empty flag means no entries left
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tdata_o[32] |-> m_tdata_o[37:33] == '0)
    else $error("empty flag with nonzero count");

  // a dequeue on an empty queue returns zero and leaves it empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tuser_o == STATUS_EMPTY |-> m_tdata_o[32] && m_tdata_o[31:0] == '0)
    else $error("bad empty-dequeue result");

  // an enqueue on a full queue returns zero and is never reported empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tuser_o == STATUS_FULL |-> !m_tdata_o[32] && m_tdata_o[31:0] == '0)
    else $error("bad full-enqueue result");

  // an accepted input always yields a result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_o |=> m_tvalid_o)
    else $error("missing result");

endmodule

bind min_priority_queue mpq_checker u_mpq_checker (.*);
